FILE: src/hlwp_pkg.sv
// Shared constants, codes and types of the core hotplug load window policy unit.
package hlwp_pkg;

   localparam int LOAD_RING_DEPTH = 25;
   localparam int TASK_RING_DEPTH = 25;

   localparam int LPOS_W  = $clog2(LOAD_RING_DEPTH);
   localparam int TPOS_W  = $clog2(TASK_RING_DEPTH);
   localparam int LCNT_W  = $clog2(LOAD_RING_DEPTH + 1);

   localparam int LOAD_W  = 7;
   localparam int FREQ_W  = 12;
   localparam int MS_W    = 16;
   localparam int TASKS_W = 8;
   localparam int CORES_W = 4;
   localparam int LF_W    = 20;
   localparam int TASK_W  = 15;
   localparam int LEVEL_W = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam int TSUM_W = MS_W + LCNT_W;
   localparam int WSUM_W = LF_W + MS_W + LCNT_W;
   localparam int PROD_W = LEVEL_W + TSUM_W;

   localparam int BURST_SAMPLES = 5;
   localparam int TCNT_W  = $clog2(BURST_SAMPLES + 1);
   localparam int TSUM5_W = TASK_W + TCNT_W;

   localparam logic [MS_W-1:0]    SHORT_WINDOW_MS = MS_W'(1000);
   localparam logic [LOAD_W-1:0]  FULL_LOAD       = LOAD_W'(100);
   localparam logic [TASK_W-1:0]  TASK_SCALE      = TASK_W'(100);
   localparam logic [CORES_W-1:0] ONE_CORE        = CORES_W'(1);
   localparam logic [CORES_W-1:0] TWO_CORES       = CORES_W'(2);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IDLE_LEVEL  = 3'd0,
      CSR_DROP_LEVEL  = 3'd1,
      CSR_UP_FREQ     = 3'd2,
      CSR_UP_LOAD     = 3'd3,
      CSR_UP_TASK_AVG = 3'd4,
      CSR_BURST_TASK  = 3'd5,
      CSR_DOWN_TASK   = 3'd6,
      CSR_LONG_WINDOW = 3'd7
   } csr_index_type;

   // request to the window unit
   typedef struct packed {
      logic                start;
      logic [MS_W-1:0]     window;
      logic [LEVEL_W-1:0]  level;
   } win_cmd_type;

   // status from the window unit
   typedef struct packed {
      logic done;
      logic below;
   } win_stat_type;

endpackage

FILE: src/hlwp_if.sv
// Channel interfaces: sample requests, decision responses, register writes.
interface hlwp_req_if import hlwp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LOAD_W-1:0]  load_first;
   logic [LOAD_W-1:0]  load_second;
   logic [FREQ_W-1:0]  freq_mhz;
   logic [MS_W-1:0]    elapsed_ms;
   logic [TASKS_W-1:0] running_tasks;
   logic [CORES_W-1:0] online_cores;
   modport source (output valid, load_first, load_second, freq_mhz, elapsed_ms,
                   running_tasks, online_cores, input ready);
   modport sink   (input valid, load_first, load_second, freq_mhz, elapsed_ms,
                   running_tasks, online_cores, output ready);
endinterface

interface hlwp_rsp_if import hlwp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CORES_W-1:0] needed_cores;
   logic               real_idle;
   modport source (output valid, needed_cores, real_idle, input ready);
   modport sink   (input valid, needed_cores, real_idle, output ready);
endinterface

interface hlwp_csr_if import hlwp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/hlwp_window_unit.sv
// Shared multiply-accumulate unit: walks the load ring and compares the window average.
module hlwp_window_unit import hlwp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  win_cmd_type        cmd,
   input  logic [LPOS_W-1:0]  head,
   output logic [LPOS_W-1:0]  rd_addr,
   input  logic [LF_W-1:0]    rd_lf,
   input  logic [MS_W-1:0]    rd_ms,
   output win_stat_type       stat
);

   typedef enum logic [3:0] {
      U_IDLE = 4'b0001,
      U_WALK = 4'b0010,
      U_MUL  = 4'b0100,
      U_CMP  = 4'b1000
   } unit_state_type;

   unit_state_type       state_ff, state_in;
   logic [LPOS_W-1:0]    ptr_ff, ptr_in;
   logic [LCNT_W-1:0]    cnt_ff, cnt_in;
   logic [WSUM_W-1:0]    wsum_ff, wsum_in;
   logic [TSUM_W-1:0]    tsum_ff, tsum_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [MS_W-1:0]      window_ff, window_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LF_W+MS_W-1:0] term;
   logic                 more;

   assign rd_addr = ptr_ff;
   assign term    = (LF_W+MS_W)'(rd_lf) * (LF_W+MS_W)'(rd_ms);
   assign more    = (tsum_ff < TSUM_W'(window_ff)) && (cnt_ff < LCNT_W'(LOAD_RING_DEPTH));

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      cnt_in    = cnt_ff;
      wsum_in   = wsum_ff;
      tsum_in   = tsum_ff;
      prod_in   = prod_ff;
      window_in = window_ff;
      level_in  = level_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               ptr_in    = head;
               cnt_in    = '0;
               wsum_in   = '0;
               tsum_in   = '0;
               window_in = cmd.window;
               level_in  = cmd.level;
               state_in  = U_WALK;
            end
         end
         U_WALK: begin
            if (more) begin
               wsum_in = wsum_ff + WSUM_W'(term);
               tsum_in = tsum_ff + TSUM_W'(rd_ms);
               ptr_in  = (ptr_ff == '0) ? LPOS_W'(LOAD_RING_DEPTH - 1) : ptr_ff - 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = U_MUL;
            end
         end
         U_MUL: begin
            // avg < level  <=>  wsum < level * tsum
            prod_in  = PROD_W'(level_ff) * PROD_W'(tsum_ff);
            state_in = U_CMP;
         end
         U_CMP:   state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_comb begin
      stat.done  = (state_ff == U_CMP);
      stat.below = (tsum_ff == '0) ? (level_ff != '0) : (WSUM_W'(wsum_ff) < WSUM_W'(prod_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ptr_ff    <= ptr_in;
      cnt_ff    <= cnt_in;
      wsum_ff   <= wsum_in;
      tsum_ff   <= tsum_in;
      prod_ff   <= prod_in;
      window_ff <= window_in;
      level_ff  <= level_in;
   end

endmodule

FILE: src/core_hotplug_load_window_policy_unit.sv
// Top level of the core hotplug load window policy unit.
// One sample word in, one decision word out. Each accepted sample advances the
// load ring (only when elapsed_ms is nonzero) and the task ring, then walks the
// load ring newest first through one shared multiply-accumulate unit, once for
// the long_window_ms idle average and once for the 1000 ms drop average, then
// sums the newest five task entries. The long window walk visits 0 to 25 load
// entries and the 1000 ms walk visits 1 to 25; the two walks pass one after the
// other through the shared unit. req_ch.ready is high only while no sample is
// in work; a finished result waits in the output register while the next sample
// is taken. Register writes are taken at any time (csr_ch.ready is tied high)
// but belong only to idle periods. Rings and positions clear at reset; the
// first write after reset lands at position 1.
module core_hotplug_load_window_policy_unit import hlwp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hlwp_req_if.sink   req_ch,
   hlwp_rsp_if.source rsp_ch,
   hlwp_csr_if.sink   csr_ch
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_LSTART = 7'b0000010,
      ST_LWAIT  = 7'b0000100,
      ST_SSTART = 7'b0001000,
      ST_SWAIT  = 7'b0010000,
      ST_TASKS  = 7'b0100000,
      ST_DECIDE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [LEVEL_W-1:0] idle_level_ff, drop_level_ff;
   logic [FREQ_W-1:0]  up_freq_ff;
   logic [LOAD_W-1:0]  up_load_ff;
   logic [TASK_W-1:0]  up_task_avg_ff, burst_task_ff, down_task_ff;
   logic [MS_W-1:0]    long_window_ff;

   // rings
   logic [LF_W-1:0]    lf_ring_ff   [LOAD_RING_DEPTH];
   logic [MS_W-1:0]    ms_ring_ff   [LOAD_RING_DEPTH];
   logic [TASK_W-1:0]  task_ring_ff [TASK_RING_DEPTH];
   logic [LPOS_W-1:0]  lpos_ff, lpos_next;
   logic [TPOS_W-1:0]  tpos_ff, tpos_next;

   // sample held during work
   logic [LOAD_W-1:0]  load0_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic [CORES_W-1:0] online_ff;
   logic [TASK_W-1:0]  task1_ff;
   logic               idle_ff, drop_ok_ff;

   // task sum walk
   logic [TPOS_W-1:0]  tptr_ff, tptr_in;
   logic [TCNT_W-1:0]  tcnt_ff, tcnt_in;
   logic [TSUM5_W-1:0] tsum5_ff, tsum5_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CORES_W-1:0] rsp_need_ff, rsp_need_in;
   logic               rsp_idle_ff, rsp_idle_in;

   logic               accept, load_out;
   logic [LOAD_W:0]    load_sum;
   logic [LF_W-1:0]    lf_new;
   logic [TASK_W-1:0]  task_new;
   logic [CORES_W-1:0] need;
   logic               up_rule, burst_rule, down_rule;

   win_cmd_type        win_cmd;
   win_stat_type       win_stat;
   logic [LPOS_W-1:0]  win_addr;

   hlwp_window_unit u_window (
      .clock   (clock),
      .reset   (reset),
      .cmd     (win_cmd),
      .head    (lpos_ff),
      .rd_addr (win_addr),
      .rd_lf   (lf_ring_ff[win_addr]),
      .rd_ms   (ms_ring_ff[win_addr]),
      .stat    (win_stat)
   );

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.needed_cores = rsp_need_ff;
   assign rsp_ch.real_idle    = rsp_idle_ff;

   assign load_sum  = (LOAD_W+1)'(req_ch.load_first) + (LOAD_W+1)'(req_ch.load_second);
   assign lf_new    = LF_W'(load_sum) * LF_W'(req_ch.freq_mhz);
   assign task_new  = TASK_W'(req_ch.running_tasks) * TASK_SCALE;
   assign lpos_next = (lpos_ff == LPOS_W'(LOAD_RING_DEPTH - 1)) ? '0 : lpos_ff + 1'b1;
   assign tpos_next = (tpos_ff == TPOS_W'(TASK_RING_DEPTH - 1)) ? '0 : tpos_ff + 1'b1;

   // window unit requests
   always_comb begin
      win_cmd.start  = (state_ff == ST_LSTART) || (state_ff == ST_SSTART);
      win_cmd.window = (state_ff == ST_SSTART) ? SHORT_WINDOW_MS : long_window_ff;
      win_cmd.level  = (state_ff == ST_SSTART) ? drop_level_ff : idle_level_ff;
   end

   // decision rules; average comparisons are done without division
   always_comb begin
      up_rule    = (freq_ff >= up_freq_ff) && (load0_ff >= up_load_ff) &&
                   (tsum5_ff >= TSUM5_W'(up_task_avg_ff) * TSUM5_W'(BURST_SAMPLES));
      burst_rule = (load0_ff == FULL_LOAD) && (task1_ff >= burst_task_ff);
      down_rule  = (task1_ff <= down_task_ff) && (load0_ff < FULL_LOAD) && drop_ok_ff;
      need = online_ff;
      if (online_ff == ONE_CORE) begin
         if (up_rule || burst_rule) need = TWO_CORES;
      end else if (online_ff == TWO_CORES) begin
         if (down_rule) need = ONE_CORE;
      end
   end

   assign load_out = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      tptr_in  = tptr_ff;
      tcnt_in  = tcnt_ff;
      tsum5_in = tsum5_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tptr_in  = tpos_next;
               tcnt_in  = '0;
               tsum5_in = '0;
               state_in = ST_LSTART;
            end
         end
         ST_LSTART: state_in = ST_LWAIT;
         ST_LWAIT:  if (win_stat.done) state_in = ST_SSTART;
         ST_SSTART: state_in = ST_SWAIT;
         ST_SWAIT:  if (win_stat.done) state_in = ST_TASKS;
         ST_TASKS: begin
            tsum5_in = tsum5_ff + TSUM5_W'(task_ring_ff[tptr_ff]);
            tptr_in  = (tptr_ff == '0) ? TPOS_W'(TASK_RING_DEPTH - 1) : tptr_ff - 1'b1;
            tcnt_in  = tcnt_ff + 1'b1;
            if (tcnt_ff == TCNT_W'(BURST_SAMPLES - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_need_in  = rsp_need_ff;
      rsp_idle_in  = rsp_idle_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_need_in  = need;
         rsp_idle_in  = idle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         lpos_ff        <= '0;
         tpos_ff        <= '0;
         idle_level_ff  <= LEVEL_W'(9152);
         drop_level_ff  <= LEVEL_W'(5720);
         up_freq_ff     <= FREQ_W'(676);
         up_load_ff     <= LOAD_W'(50);
         up_task_avg_ff <= TASK_W'(150);
         burst_task_ff  <= TASK_W'(1000);
         down_task_ff   <= TASK_W'(200);
         long_window_ff <= MS_W'(5000);
         for (int i = 0; i < LOAD_RING_DEPTH; i++) begin
            lf_ring_ff[i] <= '0;
            ms_ring_ff[i] <= '0;
         end
         for (int i = 0; i < TASK_RING_DEPTH; i++) begin
            task_ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_ch.elapsed_ms != '0) begin
               lpos_ff              <= lpos_next;
               lf_ring_ff[lpos_next] <= lf_new;
               ms_ring_ff[lpos_next] <= req_ch.elapsed_ms;
            end
            tpos_ff                 <= tpos_next;
            task_ring_ff[tpos_next] <= task_new;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_IDLE_LEVEL:  idle_level_ff  <= LEVEL_W'(csr_ch.data);
               CSR_DROP_LEVEL:  drop_level_ff  <= LEVEL_W'(csr_ch.data);
               CSR_UP_FREQ:     up_freq_ff     <= FREQ_W'(csr_ch.data);
               CSR_UP_LOAD:     up_load_ff     <= LOAD_W'(csr_ch.data);
               CSR_UP_TASK_AVG: up_task_avg_ff <= TASK_W'(csr_ch.data);
               CSR_BURST_TASK:  burst_task_ff  <= TASK_W'(csr_ch.data);
               CSR_DOWN_TASK:   down_task_ff   <= TASK_W'(csr_ch.data);
               CSR_LONG_WINDOW: long_window_ff <= MS_W'(csr_ch.data);
               default: ;
            endcase
         end
      end
      if (accept) begin
         load0_ff  <= req_ch.load_first;
         freq_ff   <= req_ch.freq_mhz;
         online_ff <= req_ch.online_cores;
         task1_ff  <= task_new;
      end
      if (state_ff == ST_LWAIT && win_stat.done) idle_ff    <= win_stat.below;
      if (state_ff == ST_SWAIT && win_stat.done) drop_ok_ff <= win_stat.below;
      tptr_ff     <= tptr_in;
      tcnt_ff     <= tcnt_in;
      tsum5_ff    <= tsum5_in;
      rsp_need_ff <= rsp_need_in;
      rsp_idle_ff <= rsp_idle_in;
   end

   // ring positions never leave the ring
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (lpos_ff < LPOS_W'(LOAD_RING_DEPTH)) && (tpos_ff < TPOS_W'(TASK_RING_DEPTH)))
      else $error("ring position out of range");

   // an accepted sample always starts the long-window walk
   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LSTART))
      else $error("sample accepted without starting the walk");

   // a decided result waits while the output register is still occupied
   a_hold_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && rsp_valid_ff && !rsp_ch.ready)
      |=> (state_ff == ST_DECIDE) && rsp_valid_ff && $stable(rsp_need_ff))
      else $error("result overwritten while pending");

   // the window unit reports only while the sequencer is waiting on it
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      win_stat.done |-> (state_ff == ST_LWAIT || state_ff == ST_SWAIT))
      else $error("window unit finished outside a wait state");

endmodule
